FILE: design/skf_pkg.sv
`default_nettype none

package skf_pkg;

   // fixed point and port geometry
   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] CSR_PROCESS_NOISE = 3'd0;
   localparam logic [2:0] CSR_MEASURE_NOISE = 3'd1;
   localparam logic [2:0] CSR_STATE_GAIN    = 3'd2;
   localparam logic [2:0] CSR_CONTROL_GAIN  = 3'd3;
   localparam logic [2:0] CSR_OBSERVE_GAIN  = 3'd4;

   // register reset values
   localparam logic [30:0]        PROCESS_NOISE_RST = 31'd655;
   localparam logic [30:0]        MEASURE_NOISE_RST = 31'd65536;
   localparam logic signed [31:0] STATE_GAIN_RST    = 32'sd65536;
   localparam logic signed [31:0] CONTROL_GAIN_RST  = 32'sd0;
   localparam logic signed [31:0] OBSERVE_GAIN_RST  = 32'sd65536;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // micro-op codes
   localparam logic [2:0] UOP_MUL = 3'd0;  // mp = a * b (raw)
   localparam logic [2:0] UOP_LDP = 3'd1;  // acc = floor(mp)
   localparam logic [2:0] UOP_ADP = 3'd2;  // acc += floor(mp)
   localparam logic [2:0] UOP_SAT = 3'd3;  // dst = sat(a +/- acc)
   localparam logic [2:0] UOP_DIV = 3'd4;  // dst = a / b, iterative
   localparam logic [2:0] UOP_BRS = 3'd5;  // jump to target when started
   localparam logic [2:0] UOP_FIN = 3'd6;  // post result, back to idle

   // operand codes
   localparam logic [3:0] OPD_ZERO = 4'd0;
   localparam logic [3:0] OPD_R    = 4'd1;
   localparam logic [3:0] OPD_Q    = 4'd2;
   localparam logic [3:0] OPD_A    = 4'd3;
   localparam logic [3:0] OPD_B    = 4'd4;
   localparam logic [3:0] OPD_C    = 4'd5;
   localparam logic [3:0] OPD_Z    = 4'd6;
   localparam logic [3:0] OPD_U    = 4'd7;
   localparam logic [3:0] OPD_X    = 4'd8;
   localparam logic [3:0] OPD_COV  = 4'd9;
   localparam logic [3:0] OPD_T0   = 4'd10;
   localparam logic [3:0] OPD_T1   = 4'd11;
   localparam logic [3:0] OPD_T2   = 4'd12;
   localparam logic [3:0] OPD_T3   = 4'd13;

   localparam int         UPC_W   = 6;
   localparam logic [5:0] L_START = 6'd7;  // entry of the regular update

   typedef struct packed {
      logic [2:0] op;
      logic [3:0] src_a;
      logic [3:0] src_b;
      logic [3:0] dst;
      logic       neg;
      logic [5:0] target;
   } uop_type;

   function automatic uop_type uop_make(input logic [2:0] op, input logic [3:0] src_a,
                                        input logic [3:0] src_b, input logic [3:0] dst,
                                        input logic neg, input logic [5:0] target);
      uop_type u;
      u.op     = op;
      u.src_a  = src_a;
      u.src_b  = src_b;
      u.dst    = dst;
      u.neg    = neg;
      u.target = target;
      return u;
   endfunction

   // control store
   function automatic uop_type ucode_fetch(input logic [UPC_W-1:0] addr);
      uop_type u;
      case (addr)
         // first word after reset: x = z/c, cov = q/sat(c*c)
         6'd0:  u = uop_make(UOP_BRS, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, L_START);
         6'd1:  u = uop_make(UOP_MUL, OPD_C,    OPD_C,    OPD_ZERO, 1'b0, 6'd0);
         6'd2:  u = uop_make(UOP_LDP, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         6'd3:  u = uop_make(UOP_SAT, OPD_ZERO, OPD_ZERO, OPD_T0,   1'b0, 6'd0);
         6'd4:  u = uop_make(UOP_DIV, OPD_Z,    OPD_C,    OPD_X,    1'b0, 6'd0);
         6'd5:  u = uop_make(UOP_DIV, OPD_Q,    OPD_T0,   OPD_COV,  1'b0, 6'd0);
         6'd6:  u = uop_make(UOP_FIN, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         // pred = sat(a*x + b*u) -> t0
         6'd7:  u = uop_make(UOP_MUL, OPD_A,    OPD_X,    OPD_ZERO, 1'b0, 6'd0);
         6'd8:  u = uop_make(UOP_LDP, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         6'd9:  u = uop_make(UOP_MUL, OPD_B,    OPD_U,    OPD_ZERO, 1'b0, 6'd0);
         6'd10: u = uop_make(UOP_ADP, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         6'd11: u = uop_make(UOP_SAT, OPD_ZERO, OPD_ZERO, OPD_T0,   1'b0, 6'd0);
         // pc = sat(sat(a*a)*cov + r) -> t1
         6'd12: u = uop_make(UOP_MUL, OPD_A,    OPD_A,    OPD_ZERO, 1'b0, 6'd0);
         6'd13: u = uop_make(UOP_LDP, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         6'd14: u = uop_make(UOP_SAT, OPD_ZERO, OPD_ZERO, OPD_T1,   1'b0, 6'd0);
         6'd15: u = uop_make(UOP_MUL, OPD_T1,   OPD_COV,  OPD_ZERO, 1'b0, 6'd0);
         6'd16: u = uop_make(UOP_LDP, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         6'd17: u = uop_make(UOP_SAT, OPD_R,    OPD_ZERO, OPD_T1,   1'b0, 6'd0);
         // num = sat(pc*c) -> t2
         6'd18: u = uop_make(UOP_MUL, OPD_T1,   OPD_C,    OPD_ZERO, 1'b0, 6'd0);
         6'd19: u = uop_make(UOP_LDP, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         6'd20: u = uop_make(UOP_SAT, OPD_ZERO, OPD_ZERO, OPD_T2,   1'b0, 6'd0);
         // den = sat(sat(c*c)*pc + q) -> t3
         6'd21: u = uop_make(UOP_MUL, OPD_C,    OPD_C,    OPD_ZERO, 1'b0, 6'd0);
         6'd22: u = uop_make(UOP_LDP, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         6'd23: u = uop_make(UOP_SAT, OPD_ZERO, OPD_ZERO, OPD_T3,   1'b0, 6'd0);
         6'd24: u = uop_make(UOP_MUL, OPD_T3,   OPD_T1,   OPD_ZERO, 1'b0, 6'd0);
         6'd25: u = uop_make(UOP_LDP, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         6'd26: u = uop_make(UOP_SAT, OPD_Q,    OPD_ZERO, OPD_T3,   1'b0, 6'd0);
         // gain k -> t2
         6'd27: u = uop_make(UOP_DIV, OPD_T2,   OPD_T3,   OPD_T2,   1'b0, 6'd0);
         // innovation = sat(z - c*pred) -> t3
         6'd28: u = uop_make(UOP_MUL, OPD_C,    OPD_T0,   OPD_ZERO, 1'b0, 6'd0);
         6'd29: u = uop_make(UOP_LDP, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         6'd30: u = uop_make(UOP_SAT, OPD_Z,    OPD_ZERO, OPD_T3,   1'b1, 6'd0);
         // x = sat(pred + k*innov)
         6'd31: u = uop_make(UOP_MUL, OPD_T2,   OPD_T3,   OPD_ZERO, 1'b0, 6'd0);
         6'd32: u = uop_make(UOP_LDP, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         6'd33: u = uop_make(UOP_SAT, OPD_T0,   OPD_ZERO, OPD_X,    1'b0, 6'd0);
         // cov = sat(pc - sat(k*c)*pc)
         6'd34: u = uop_make(UOP_MUL, OPD_T2,   OPD_C,    OPD_ZERO, 1'b0, 6'd0);
         6'd35: u = uop_make(UOP_LDP, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         6'd36: u = uop_make(UOP_SAT, OPD_ZERO, OPD_ZERO, OPD_T3,   1'b0, 6'd0);
         6'd37: u = uop_make(UOP_MUL, OPD_T3,   OPD_T1,   OPD_ZERO, 1'b0, 6'd0);
         6'd38: u = uop_make(UOP_LDP, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         6'd39: u = uop_make(UOP_SAT, OPD_T1,   OPD_ZERO, OPD_COV,  1'b1, 6'd0);
         6'd40: u = uop_make(UOP_FIN, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
         default: u = uop_make(UOP_FIN, OPD_ZERO, OPD_ZERO, OPD_ZERO, 1'b0, 6'd0);
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

FILE: design/scalar_kalman_filter.sv
// Scalar Kalman filter, signed fixed point with FRAC_BITS fraction bits.
// Input stream (req_): one word carries a measurement z and a control u.
// Output stream (rsp_): one word per input, the new estimate, with tuser
// flagging a saturation or a zero divisor somewhere in that update.
// The APB port (csr_) holds r, q, a, b and c at byte addresses 0..16; write
// it only while the filter is idle.
// The update runs as a microprogram on one 32x32 multiplier, one
// 66-bit saturating adder and a one-bit-per-cycle divider. The first word
// after reset seeds the estimate and covariance (initialization); every
// later word runs the regular update. The divider's 32+FRAC_BITS
// iterations dominate. One word is in flight at a time; req_tready is
// high only while the sequencer is idle.
// The result sits in an output register; a new word is accepted while it
// waits. If the receiver still stalls when the next result is done, the
// sequencer holds on its last step until rsp_tready.
// Reset (synchronous, active high) restores the register defaults, clears
// the estimate, covariance and started flag, and drops rsp_tvalid.
`default_nettype none

module scalar_kalman_filter #(
   parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   // input stream
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [63:0]                      req_tdata,   // [31:0] measurement, [63:32] control
   // result stream
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [31:0]                      rsp_tdata,   // [31:0] estimate
   output logic [0:0]                       rsp_tuser,   // [0] math_fault
   // configuration
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [skf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [skf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [skf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import skf_pkg::*;

   localparam int NUM_W  = 32 + FRAC_BITS;     // dividend bits after scaling
   localparam int DCNT_W = $clog2(NUM_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DIVW = 2'd2;

   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   // control registers
   logic [1:0]        state_ff, state_in;
   logic [UPC_W-1:0]  upc_ff, upc_in;
   logic              started_ff, started_in;
   logic              fault_ff, fault_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   // configuration registers
   logic [30:0]        r_ff, r_in;
   logic [30:0]        q_ff, q_in;
   logic signed [31:0] a_ff, a_in;
   logic signed [31:0] b_ff, b_in;
   logic signed [31:0] c_ff, c_in;

   // datapath registers
   logic signed [31:0] z_ff, z_in;
   logic signed [31:0] u_ff, u_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] cov_ff, cov_in;
   logic signed [31:0] t0_ff, t0_in;
   logic signed [31:0] t1_ff, t1_in;
   logic signed [31:0] t2_ff, t2_in;
   logic signed [31:0] t3_ff, t3_in;
   logic signed [63:0] mp_ff, mp_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [31:0]        rem_ff, rem_in;
   logic [NUM_W-1:0]   dq_ff, dq_in;
   logic [31:0]        dvs_ff, dvs_in;
   logic               dneg_ff, dneg_in;
   logic [31:0]        rsp_est_ff, rsp_est_in;
   logic               rsp_fault_ff, rsp_fault_in;

   uop_type            uop;
   logic signed [31:0] opa, opb;
   logic signed [63:0] mp_floor;
   logic signed [65:0] acc_ext, sat_sum;
   logic signed [31:0] sat_val;
   logic               sat_clip;
   logic [31:0]        abs_a, abs_b;
   logic [32:0]        trial;
   logic               qbit;
   logic [NUM_W-1:0]   quo;
   logic               wr_en;
   logic [3:0]         wr_dst;
   logic signed [31:0] wr_data;
   logic               wr_fault;
   logic               csr_wr;

   assign uop = ucode_fetch(upc_ff);

   // operand selection
   function automatic logic signed [31:0] opd_sel(input logic [3:0] code,
         input logic [30:0] r, input logic [30:0] q, input logic signed [31:0] a,
         input logic signed [31:0] b, input logic signed [31:0] c,
         input logic signed [31:0] z, input logic signed [31:0] u,
         input logic signed [31:0] x, input logic signed [31:0] cov,
         input logic signed [31:0] t0, input logic signed [31:0] t1,
         input logic signed [31:0] t2, input logic signed [31:0] t3);
      logic signed [31:0] v;
      case (code)
         OPD_R:   v = $signed({1'b0, r});
         OPD_Q:   v = $signed({1'b0, q});
         OPD_A:   v = a;
         OPD_B:   v = b;
         OPD_C:   v = c;
         OPD_Z:   v = z;
         OPD_U:   v = u;
         OPD_X:   v = x;
         OPD_COV: v = cov;
         OPD_T0:  v = t0;
         OPD_T1:  v = t1;
         OPD_T2:  v = t2;
         OPD_T3:  v = t3;
         default: v = '0;
      endcase
      return v;
   endfunction

   assign opa = opd_sel(uop.src_a, r_ff, q_ff, a_ff, b_ff, c_ff, z_ff, u_ff, x_ff, cov_ff,
                        t0_ff, t1_ff, t2_ff, t3_ff);
   assign opb = opd_sel(uop.src_b, r_ff, q_ff, a_ff, b_ff, c_ff, z_ff, u_ff, x_ff, cov_ff,
                        t0_ff, t1_ff, t2_ff, t3_ff);

   // product scaling rounds toward minus infinity
   assign mp_floor = mp_ff >>> FRAC_BITS;

   // saturating add: a +/- acc
   always_comb begin
      acc_ext = {{2{acc_ff[63]}}, acc_ff};
      sat_sum = {{34{opa[31]}}, opa} + (uop.neg ? -acc_ext : acc_ext);
      sat_clip = 1'b0;
      if (sat_sum > SAT_HI) begin
         sat_val  = S32_MAX;
         sat_clip = 1'b1;
      end else if (sat_sum < SAT_LO) begin
         sat_val  = S32_MIN;
         sat_clip = 1'b1;
      end else begin
         sat_val = sat_sum[31:0];
      end
   end

   // divider step: restoring, one quotient bit per cycle on magnitudes
   assign abs_a = opa[31] ? 32'(-opa) : 32'(opa);
   assign abs_b = opb[31] ? 32'(-opb) : 32'(opb);
   assign trial = {rem_ff, dq_ff[NUM_W-1]};
   assign qbit  = (trial >= {1'b0, dvs_ff});
   assign quo   = {dq_ff[NUM_W-2:0], qbit};

   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      upc_in       = upc_ff;
      started_in   = started_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      dcnt_in      = dcnt_ff;
      z_in         = z_ff;
      u_in         = u_ff;
      mp_in        = mp_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      dvs_in       = dvs_ff;
      dneg_in      = dneg_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_fault_in = rsp_fault_ff;
      wr_en        = 1'b0;
      wr_dst       = uop.dst;
      wr_data      = sat_val;
      wr_fault     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               z_in     = $signed(req_tdata[31:0]);
               u_in     = $signed(req_tdata[63:32]);
               upc_in   = '0;
               fault_in = 1'b0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            upc_in = upc_ff + UPC_W'(1);
            case (uop.op)
               UOP_MUL: mp_in = 64'(opa) * 64'(opb);
               UOP_LDP: acc_in = mp_floor;
               UOP_ADP: acc_in = acc_ff + mp_floor;
               UOP_SAT: begin
                  wr_en    = 1'b1;
                  wr_data  = sat_val;
                  wr_fault = sat_clip;
               end
               UOP_DIV: begin
                  if (opb == '0) begin
                     // zero divisor: saturate by the numerator's sign
                     wr_en    = 1'b1;
                     wr_data  = opa[31] ? S32_MIN : S32_MAX;
                     wr_fault = 1'b1;
                  end else begin
                     upc_in   = upc_ff;
                     dneg_in  = opa[31] ^ opb[31];
                     dq_in    = {abs_a, {FRAC_BITS{1'b0}}};
                     dvs_in   = abs_b;
                     rem_in   = '0;
                     dcnt_in  = '0;
                     state_in = ST_DIVW;
                  end
               end
               UOP_BRS: begin
                  if (started_ff) begin
                     upc_in = uop.target;
                  end
               end
               UOP_FIN: begin
                  if (!rsp_valid_ff || rsp_tready) begin
                     rsp_valid_in = 1'b1;
                     rsp_est_in   = x_ff;
                     rsp_fault_in = fault_ff;
                     started_in   = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     upc_in = upc_ff;
                  end
               end
               default: ;
            endcase
         end
         ST_DIVW: begin
            rem_in  = qbit ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
            dq_in   = quo;
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(NUM_W - 1)) begin
               // last bit: apply sign and clamp to 32 bits
               wr_en    = 1'b1;
               state_in = ST_RUN;
               upc_in   = upc_ff + UPC_W'(1);
               if (dneg_ff) begin
                  if ((|quo[NUM_W-1:32]) || (quo[31] && (|quo[30:0]))) begin
                     wr_data  = S32_MIN;
                     wr_fault = 1'b1;
                  end else begin
                     wr_data = $signed(-quo[31:0]);
                  end
               end else begin
                  if (|quo[NUM_W-1:31]) begin
                     wr_data  = S32_MAX;
                     wr_fault = 1'b1;
                  end else begin
                     wr_data = $signed(quo[31:0]);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (wr_fault) begin
         fault_in = 1'b1;
      end
   end

   // register file writeback
   always_comb begin
      x_in   = (wr_en && wr_dst == OPD_X)   ? wr_data : x_ff;
      cov_in = (wr_en && wr_dst == OPD_COV) ? wr_data : cov_ff;
      t0_in  = (wr_en && wr_dst == OPD_T0)  ? wr_data : t0_ff;
      t1_in  = (wr_en && wr_dst == OPD_T1)  ? wr_data : t1_ff;
      t2_in  = (wr_en && wr_dst == OPD_T2)  ? wr_data : t2_ff;
      t3_in  = (wr_en && wr_dst == OPD_T3)  ? wr_data : t3_ff;
   end

   // configuration writes
   always_comb begin
      r_in = r_ff;
      q_in = q_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      if (csr_wr) begin
         case (csr_paddr[4:2])
            CSR_PROCESS_NOISE: r_in = csr_pwdata[30:0];
            CSR_MEASURE_NOISE: q_in = csr_pwdata[30:0];
            CSR_STATE_GAIN:    a_in = $signed(csr_pwdata);
            CSR_CONTROL_GAIN:  b_in = $signed(csr_pwdata);
            CSR_OBSERVE_GAIN:  c_in = $signed(csr_pwdata);
            default: ;
         endcase
      end
   end

   // configuration reads
   always_comb begin
      case (csr_paddr[4:2])
         CSR_PROCESS_NOISE: csr_prdata = {1'b0, r_ff};
         CSR_MEASURE_NOISE: csr_prdata = {1'b0, q_ff};
         CSR_STATE_GAIN:    csr_prdata = a_ff;
         CSR_CONTROL_GAIN:  csr_prdata = b_ff;
         CSR_OBSERVE_GAIN:  csr_prdata = c_ff;
         default:           csr_prdata = '0;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         upc_ff       <= '0;
         started_ff   <= 1'b0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
         r_ff         <= PROCESS_NOISE_RST;
         q_ff         <= MEASURE_NOISE_RST;
         a_ff         <= STATE_GAIN_RST;
         b_ff         <= CONTROL_GAIN_RST;
         c_ff         <= OBSERVE_GAIN_RST;
         x_ff         <= '0;
         cov_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         upc_ff       <= upc_in;
         started_ff   <= started_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         dcnt_ff      <= dcnt_in;
         r_ff         <= r_in;
         q_ff         <= q_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         x_ff         <= x_in;
         cov_ff       <= cov_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      z_ff         <= z_in;
      u_ff         <= u_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      t3_ff        <= t3_in;
      mp_ff        <= mp_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      dq_ff        <= dq_in;
      dvs_ff       <= dvs_in;
      dneg_ff      <= dneg_in;
      rsp_est_ff   <= rsp_est_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_est_ff;
   assign rsp_tuser  = rsp_fault_ff;
   assign csr_pready = 1'b1;

   // an accepted word starts the program at its first step
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_RUN && upc_ff == '0))
      else $error("accepted word did not start the microprogram");

   // a new result appears only from the final step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RUN && uop.op == UOP_FIN))
      else $error("result posted outside the final step");

   // divider never runs past its bit count
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVW) |-> (dcnt_ff <= DCNT_W'(NUM_W - 1)))
      else $error("divider overran");

   // only reset clears the started flag
   a_started_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(started_ff))
      else $error("started flag dropped without reset");

   // a zero divisor always marks the word as faulted
   a_div0_fault: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && uop.op == UOP_DIV && opb == '0) |=> fault_ff)
      else $error("zero divisor without fault");

endmodule

`default_nettype wire

FILE: verif/skf_estimate_checker.sv
`timescale 1ns / 1ps

module skf_estimate_checker (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   input  wire                             req_tready,
   input  wire  [63:0]                     req_tdata,    // [31:0] measurement, [63:32] control
   input  wire                             rsp_tvalid,
   input  wire                             rsp_tready,
   input  wire  [31:0]                     rsp_tdata,    // [31:0] estimate
   input  wire  [0:0]                      rsp_tuser,    // [0] math_fault
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire  [skf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [skf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  wire  [skf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input  wire                             csr_pready,
   output int                              words_checked,
   output int                              words_pending,
   output int                              mismatches,
   output int                              fault_words
);
   import skf_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;

   typedef struct packed {
      logic signed [31:0] estimate;
      logic               math_fault;
   } estimate_word_type;

   // estimates still owed by the filter, oldest first
   estimate_word_type expected_estimates[$];

   // shadow of the filter registers
   logic [30:0]        noise_r;
   logic [30:0]        noise_q;
   logic signed [31:0] gain_a;
   logic signed [31:0] gain_b;
   logic signed [31:0] gain_c;

   // shadow of the filter state
   logic signed [31:0] x_est;
   logic signed [31:0] p_cov;
   logic               primed;

   int seen_cnt  = 0;
   int miss_cnt  = 0;
   int fault_cnt = 0;

   // clamp to 32 bits signed, flag any clipping
   function automatic logic signed [31:0] clamp32(input longint v, inout logic flt);
      if (v > longint'(S32_MAX)) begin
         flt = 1'b1;
         return S32_MAX;
      end
      if (v < longint'(S32_MIN)) begin
         flt = 1'b1;
         return S32_MIN;
      end
      return v[31:0];
   endfunction

   // full product, floored back to fixed point (arithmetic shift floors)
   function automatic longint mul_floor(input logic signed [31:0] x,
                                        input logic signed [31:0] y);
      longint prod;
      prod = longint'(x) * longint'(y);
      return prod >>> FRAC;
   endfunction

   // fixed point quotient, truncated toward zero; zero divisor saturates by sign
   function automatic logic signed [31:0] div_q(input logic signed [31:0] n,
                                                input logic signed [31:0] d,
                                                inout logic flt);
      if (d == 0) begin
         flt = 1'b1;
         return (n >= 0) ? S32_MAX : S32_MIN;
      end
      return clamp32((longint'(n) <<< FRAC) / longint'(d), flt);
   endfunction

   // one filter step on the shadow state
   function automatic estimate_word_type kalman_update(input logic signed [31:0] z,
                                                       input logic signed [31:0] u);
      logic               flt;
      logic signed [31:0] q_s, r_s, cc, aa, pred, pc, num, den, k, innov, kc;
      estimate_word_type  w;
      flt = 1'b0;
      q_s = {1'b0, noise_q};
      r_s = {1'b0, noise_r};
      if (!primed) begin
         // first word: seed estimate and covariance from the measurement
         cc     = clamp32(mul_floor(gain_c, gain_c), flt);
         x_est  = div_q(z, gain_c, flt);
         p_cov  = div_q(q_s, cc, flt);
         primed = 1'b1;
      end else begin
         pred  = clamp32(mul_floor(gain_a, x_est) + mul_floor(gain_b, u), flt);
         aa    = clamp32(mul_floor(gain_a, gain_a), flt);
         pc    = clamp32(mul_floor(aa, p_cov) + longint'(r_s), flt);
         num   = clamp32(mul_floor(pc, gain_c), flt);
         cc    = clamp32(mul_floor(gain_c, gain_c), flt);
         den   = clamp32(mul_floor(cc, pc) + longint'(q_s), flt);
         k     = div_q(num, den, flt);
         innov = clamp32(longint'(z) - mul_floor(gain_c, pred), flt);
         x_est = clamp32(longint'(pred) + mul_floor(k, innov), flt);
         kc    = clamp32(mul_floor(k, gain_c), flt);
         p_cov = clamp32(longint'(pc) - mul_floor(kc, pc), flt);
      end
      w.estimate   = x_est;
      w.math_fault = flt;
      return w;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      miss_cnt++;
      if (miss_cnt <= 10) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      estimate_word_type want;
      logic [2:0]        csr_idx;
      logic [31:0]       csr_want;
      logic              csr_known;
      if (reset) begin
         noise_r = PROCESS_NOISE_RST;
         noise_q = MEASURE_NOISE_RST;
         gain_a  = STATE_GAIN_RST;
         gain_b  = CONTROL_GAIN_RST;
         gain_c  = OBSERVE_GAIN_RST;
         x_est   = '0;
         p_cov   = '0;
         primed  = 1'b0;
         expected_estimates.delete();
      end else begin
         // result side: compare against the oldest owed estimate
         if (rsp_tvalid && rsp_tready) begin
            if (expected_estimates.size() == 0) begin
               note_mismatch("unrequested result word", '0, rsp_tdata);
            end else begin
               want = expected_estimates.pop_front();
               if (rsp_tdata !== want.estimate)
                  note_mismatch("estimate", want.estimate, rsp_tdata);
               if (rsp_tuser[0] !== want.math_fault)
                  note_mismatch("math_fault", want.math_fault, rsp_tuser[0]);
               seen_cnt++;
            end
         end
         // input side: run the step, queue the estimate
         if (req_tvalid && req_tready) begin
            want = kalman_update(req_tdata[31:0], req_tdata[63:32]);
            if (want.math_fault) fault_cnt++;
            expected_estimates.push_back(want);
         end
         // register port access phase
         if (csr_psel && csr_penable && csr_pready) begin
            csr_idx = csr_paddr[CSR_ADDR_W-1:2];
            if (csr_pwrite) begin
               case (csr_idx)
                  CSR_PROCESS_NOISE: noise_r = csr_pwdata[30:0];
                  CSR_MEASURE_NOISE: noise_q = csr_pwdata[30:0];
                  CSR_STATE_GAIN:    gain_a  = csr_pwdata[31:0];
                  CSR_CONTROL_GAIN:  gain_b  = csr_pwdata[31:0];
                  CSR_OBSERVE_GAIN:  gain_c  = csr_pwdata[31:0];
                  default: ;
               endcase
            end else begin
               csr_known = 1'b1;
               csr_want  = '0;
               case (csr_idx)
                  CSR_PROCESS_NOISE: csr_want = {1'b0, noise_r};
                  CSR_MEASURE_NOISE: csr_want = {1'b0, noise_q};
                  CSR_STATE_GAIN:    csr_want = gain_a;
                  CSR_CONTROL_GAIN:  csr_want = gain_b;
                  CSR_OBSERVE_GAIN:  csr_want = gain_c;
                  default:           csr_known = 1'b0;
               endcase
               if (csr_known && csr_prdata !== csr_want)
                  note_mismatch("register read", csr_want, csr_prdata);
            end
         end
      end
      words_checked <= seen_cnt;
      words_pending <= expected_estimates.size();
      mismatches    <= miss_cnt;
      fault_words   <= fault_cnt;
   end

endmodule

FILE: verif/tb_scalar_kalman_filter.sv
`timescale 1ns / 1ps

module tb_scalar_kalman_filter;
   import skf_pkg::*;

   localparam int HOLD_CYCLES     = 600;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 144;
   localparam int TAIL_CYCLES     = 200;

   // decodes to nothing in the register map
   localparam logic [2:0] CSR_UNUSED = 3'd5;

   localparam logic signed [31:0] ONE = 32'sd65536;

   typedef enum int {SET_TAME, SET_WILD, SET_HIGH, SET_LOW} setting_kind_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata   = '0;    // [31:0] measurement, [63:32] control
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [31:0]           rsp_tdata;           // [31:0] estimate
   logic [0:0]            rsp_tuser;           // [0] math_fault
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int words_checked;
   int words_pending;
   int mismatches;
   int fault_words;

   int words_sent = 0;
   int csr_writes = 0;
   int idle_pct   = 0;
   int stall_pct  = 0;
   int hold_token = 0;
   int hold_seen  = 0;
   int hold_left  = 0;

   scalar_kalman_filter uut (.*);

   skf_estimate_checker checker_i (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Timeout: filter stopped moving words");
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off when requested
   always @(posedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen  <= hold_token;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // one APB transfer, setup then access, then idle before returning
   task automatic csr_access(input logic [2:0] idx, input logic wr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (wr) csr_writes++;
      @(posedge clock);
   endtask

   task automatic set_filter(input logic [31:0] r, input logic [31:0] q,
                             input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c);
      csr_access(CSR_PROCESS_NOISE, 1'b1, r);
      csr_access(CSR_MEASURE_NOISE, 1'b1, q);
      csr_access(CSR_STATE_GAIN,    1'b1, a);
      csr_access(CSR_CONTROL_GAIN,  1'b1, b);
      csr_access(CSR_OBSERVE_GAIN,  1'b1, c);
   endtask

   // checker compares each read against its register shadow
   task automatic read_back;
      for (int i = CSR_PROCESS_NOISE; i <= CSR_OBSERVE_GAIN; i++)
         csr_access(3'(i), 1'b0, '0);
   endtask

   task automatic pick_settings(input setting_kind_type kind);
      logic signed [31:0] a, b, c;
      case (kind)
         SET_TAME: begin
            a = ONE / 2 + $urandom_range(0, ONE);
            b = $urandom_range(0, 2 * ONE) - ONE;
            c = ONE / 2 + $urandom_range(0, 3 * ONE / 2);
            if ($urandom_range(3) == 0) c = -c;
            set_filter($urandom_range(0, ONE), $urandom_range(0, 4 * ONE), a, b, c);
         end
         SET_WILD: set_filter($urandom, $urandom, $urandom, $urandom, $urandom);
         SET_HIGH: set_filter(32'h7FFF_FFFF, 32'h7FFF_FFFF, S32_MAX, S32_MAX, S32_MAX);
         default:  set_filter(32'h0, 32'h0, S32_MIN, S32_MIN, S32_MIN);
      endcase
   endtask

   // mostly moderate samples, one in ten over the full range
   function automatic logic [31:0] draw_sample(input int shift);
      logic signed [31:0] v;
      v = $urandom;
      if ($urandom_range(9) == 0) return v;
      return v >>> shift;
   endfunction

   // offer one word; valid stays high afterward unless the next word idles first
   task automatic send_word(input logic [31:0] z, input logic [31:0] u);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
         // sometimes arrive well after the filter went idle
         if ($urandom_range(2) == 0) repeat ($urandom_range(0, 100)) @(posedge clock);
      end
      req_tdata  <= {u, z};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // stop offering and wait until every owed estimate has come back
   task automatic drain;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (words_checked != words_sent);
   endtask

   initial begin
      setting_kind_type kind;
      do @(posedge clock); while (reset);

      // reset values, then the seeding word with c = 0: both divisors zero
      read_back();
      csr_access(CSR_OBSERVE_GAIN, 1'b1, 32'h0);
      send_word(-5 * ONE, ONE);
      drain();

      // nominal setup, field extremes
      set_filter(32'd655, ONE, ONE, ONE / 2, ONE);
      send_word(32'h0, 32'h0);
      send_word(32'h1, 32'hFFFF_FFFF);
      send_word(S32_MAX, S32_MIN);
      send_word(S32_MIN, S32_MAX);
      send_word(3 * ONE, -2 * ONE);
      send_word(32'hFFFF_FFFF, 32'h1);
      drain();

      // saturation everywhere
      set_filter(32'h7FFF_FFFF, 32'h7FFF_FFFF, S32_MAX, S32_MIN, S32_MAX);
      send_word(S32_MAX, S32_MAX);
      send_word(S32_MIN, S32_MIN);
      drain();

      // a = 0 pins pc to r; saturated denominator drives covariance negative
      set_filter(16000 * ONE, 32'h0, 32'h0, 32'h0, 2 * ONE);
      send_word(10 * ONE, 32'h0);
      drain();

      // c*c floors to zero with q = 0: zero divisor, negative numerator
      set_filter(32'h0, 32'h0, ONE, 32'h0, 32'h1);
      send_word(3 * ONE, 32'h0);
      drain();

      // c = 0: zero divisor, zero numerator
      csr_access(CSR_OBSERVE_GAIN, 1'b1, 32'h0);
      send_word(-ONE, ONE);
      drain();

      // unmapped write must be ignored; top bit of a noise register is dropped
      csr_access(CSR_UNUSED, 1'b1, $urandom);
      csr_access(CSR_PROCESS_NOISE, 1'b1, 32'hFFFF_FFFF);
      read_back();

      // random phases, each with its own settings and handshake pattern
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            2, 7:    kind = SET_WILD;
            4:       kind = SET_HIGH;
            6:       kind = SET_LOW;
            default: kind = SET_TAME;
         endcase
         pick_settings(kind);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 85; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 85; end
            default: begin idle_pct = 14; stall_pct <= 14; end
         endcase
         // long output hold-off with the sender pushing: input side must back up
         if (p == 0) hold_token <= hold_token + 1;
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            send_word(draw_sample(8), draw_sample(10));
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run: %0d measurement words, %0d register writes, %0d estimates flagged a fault",
               words_sent, csr_writes, fault_words);
      $display("Run: seeding, zero divisors, saturation, negative covariance, output hold-off");
      if (mismatches == 0 && words_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: scalar_kalman_filter.f
design/skf_pkg.sv
design/scalar_kalman_filter.sv
verif/skf_estimate_checker.sv
verif/tb_scalar_kalman_filter.sv
